@@ rtl/bfa_pkg.sv @@
// ----------------------------------------------------------------------------
// bfa_pkg: shared types and constants of the best-fit block allocator
// Transaction payloads, operation codes, register reset value, and the
// control part of the search token that moves along the cell chain.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int unsigned NUM_BLOCKS_DEF = 16;
  localparam int unsigned SIZE_BITS_DEF  = 16;

  localparam int unsigned CFG_W = 5;
  localparam logic [CFG_W-1:0] BLOCKS_IN_USE_RST = 5'd16;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [3:0]  block_index;
    logic [15:0] size;
  } bfa_in_t;

  typedef struct packed {
    logic        allocated;
    logic [3:0]  chosen_block;
    logic [15:0] remaining_after;
  } bfa_out_t;

  // control half of the search token
  typedef struct packed {
    logic vld;
    logic found;
  } bfa_tok_ctl_t;

endpackage

@@ rtl/bfa_cell.sv @@
// ----------------------------------------------------------------------------
// bfa_cell: one block of the allocator chain
// Holds one block's remaining size and updates the passing search token
// when this block fits the request better than the best one seen so far.
// ----------------------------------------------------------------------------
module bfa_cell #(
  parameter int unsigned SIZE_BITS = bfa_pkg::SIZE_BITS_DEF,
  parameter int unsigned IDX_W     = 4,
  parameter int unsigned CELL_IDX  = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_use,
  input  logic                  ld_en,
  input  logic [SIZE_BITS-1:0]  ld_val,
  input  logic                  sub_en,
  input  logic [SIZE_BITS-1:0]  req,
  input  bfa_pkg::bfa_tok_ctl_t tok_ctl_i,
  input  logic [IDX_W-1:0]      tok_idx_i,
  input  logic [SIZE_BITS-1:0]  tok_val_i,
  output bfa_pkg::bfa_tok_ctl_t tok_ctl_o,
  output logic [IDX_W-1:0]      tok_idx_o,
  output logic [SIZE_BITS-1:0]  tok_val_o
);

  logic [SIZE_BITS-1:0]  val_r, val_nxt;
  bfa_pkg::bfa_tok_ctl_t ctl_r, ctl_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [SIZE_BITS-1:0]  bval_r, bval_nxt;
  logic                  hit;

  // strictly smaller wins, so ties keep the lower index
  assign hit = tok_ctl_i.vld && in_use && (val_r >= req) &&
               (!tok_ctl_i.found || (tok_val_i > val_r));

  always_comb begin
    val_nxt = val_r;
    if (ld_en) begin
      val_nxt = ld_val;
    end else if (sub_en) begin
      val_nxt = val_r - req;
    end
    ctl_nxt.vld   = tok_ctl_i.vld;
    ctl_nxt.found = tok_ctl_i.found | hit;
    idx_nxt       = hit ? IDX_W'(CELL_IDX) : tok_idx_i;
    bval_nxt      = hit ? val_r : tok_val_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
      ctl_r <= '0;
    end else begin
      val_r <= val_nxt;
      ctl_r <= ctl_nxt;
    end
    idx_r  <= idx_nxt;
    bval_r <= bval_nxt;
  end

  assign tok_ctl_o = ctl_r;
  assign tok_idx_o = idx_r;
  assign tok_val_o = bval_r;

endmodule

@@ rtl/best_fit_block_allocator.sv @@
// ----------------------------------------------------------------------------
// best_fit_block_allocator: best-fit allocation over a chain of block cells
// Input transactions load a block's free size or request an allocation.
// An allocate transaction returns the smallest fitting block (lowest index
// on a tie) and its remaining size after subtraction, or reports no fit.
// Load transactions return nothing. An allocate launches a search token into
// cell 0; it moves one cell per cycle, and its result leaves the last cell
// for the output register that drives out_valid. in_stall is high while a
// search or its parked result is in flight; the next transaction is taken
// as soon as the result sits in the output register, even if the receiver
// stalls it. A result that finds the output register still stalled waits in
// a one-entry holding register. cfg_we writes blocks_in_use, the number of
// cells searched from index zero; write it only while the block is idle.
// Reset (rst_n low, synchronous) clears every block size to zero, sets
// blocks_in_use to 16 and empties the result path.
// ----------------------------------------------------------------------------
module best_fit_block_allocator #(
  parameter int unsigned NUM_BLOCKS = bfa_pkg::NUM_BLOCKS_DEF,
  parameter int unsigned SIZE_BITS  = bfa_pkg::SIZE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  bfa_pkg::bfa_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output bfa_pkg::bfa_out_t         out_data,
  input  logic                      cfg_we,
  input  logic [bfa_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int unsigned IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

  logic [bfa_pkg::CFG_W-1:0] biu_r;
  logic                      busy_r, busy_nxt;
  logic [SIZE_BITS-1:0]      req_r, req_nxt;
  logic                      out_vld_r, out_vld_nxt;
  bfa_pkg::bfa_out_t         out_r, out_nxt;
  logic                      pend_vld_r, pend_vld_nxt;
  bfa_pkg::bfa_out_t         pend_r, pend_nxt;

  logic                      in_acc, ld_acc, alloc_acc;
  logic [SIZE_BITS+31:0]     size_ext;
  logic [SIZE_BITS-1:0]      size_in;
  logic [SIZE_BITS-1:0]      req_cur;

  bfa_pkg::bfa_tok_ctl_t     tok_ctl [NUM_BLOCKS+1];
  logic [IDX_W-1:0]          tok_idx [NUM_BLOCKS+1];
  logic [SIZE_BITS-1:0]      tok_val [NUM_BLOCKS+1];

  logic [NUM_BLOCKS-1:0]     in_use, ld_sel, sub_sel;
  logic                      emerge;
  bfa_pkg::bfa_out_t         res;
  logic [SIZE_BITS-1:0]      rem_full;
  logic [SIZE_BITS+15:0]     rem_ext;
  logic [IDX_W+3:0]          idx_ext;
  logic                      out_free;

  assign in_stall  = busy_r;
  assign in_acc    = in_valid && !busy_r;
  assign ld_acc    = in_acc && (in_data.operation == bfa_pkg::OP_LOAD);
  assign alloc_acc = in_acc && (in_data.operation == bfa_pkg::OP_ALLOC);

  // sizes keep their low SIZE_BITS bits
  assign size_ext = {{SIZE_BITS{1'b0}}, 16'd0, in_data.size};
  assign size_in  = size_ext[SIZE_BITS-1:0];

  // cell 0 compares in the cycle the allocate is taken
  assign req_cur = alloc_acc ? size_in : req_r;

  // token injection into the head of the chain
  assign tok_ctl[0].vld   = alloc_acc;
  assign tok_ctl[0].found = 1'b0;
  assign tok_idx[0]       = '0;
  assign tok_val[0]       = '0;

  assign emerge = tok_ctl[NUM_BLOCKS].vld;

  genvar k;
  generate
    for (k = 0; k < NUM_BLOCKS; k++) begin : g_cell
      assign in_use[k]  = ({27'd0, biu_r} > 32'(k));
      assign ld_sel[k]  = ld_acc && ({28'd0, in_data.block_index} == 32'(k));
      assign sub_sel[k] = emerge && tok_ctl[NUM_BLOCKS].found &&
                          (tok_idx[NUM_BLOCKS] == IDX_W'(k));

      bfa_cell #(
        .SIZE_BITS (SIZE_BITS),
        .IDX_W     (IDX_W),
        .CELL_IDX  (k)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_use    (in_use[k]),
        .ld_en     (ld_sel[k]),
        .ld_val    (size_in),
        .sub_en    (sub_sel[k]),
        .req       (req_cur),
        .tok_ctl_i (tok_ctl[k]),
        .tok_idx_i (tok_idx[k]),
        .tok_val_i (tok_val[k]),
        .tok_ctl_o (tok_ctl[k+1]),
        .tok_idx_o (tok_idx[k+1]),
        .tok_val_o (tok_val[k+1])
      );
    end
  endgenerate

  // result of the token leaving the last cell
  assign rem_full = tok_val[NUM_BLOCKS] - req_r;
  assign rem_ext  = {16'd0, rem_full};
  assign idx_ext  = {4'd0, tok_idx[NUM_BLOCKS]};

  always_comb begin
    if (tok_ctl[NUM_BLOCKS].found) begin
      res.allocated       = 1'b1;
      res.chosen_block    = idx_ext[3:0];
      res.remaining_after = rem_ext[15:0];
    end else begin
      res = '0;
    end
  end

  assign out_free = !out_vld_r || !out_stall;

  always_comb begin
    busy_nxt     = busy_r;
    req_nxt      = req_r;
    out_vld_nxt  = out_vld_r;
    out_nxt      = out_r;
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;

    if (alloc_acc) begin
      busy_nxt = 1'b1;
      req_nxt  = size_in;
    end

    if (out_free) begin
      if (pend_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_nxt      = pend_r;
        pend_vld_nxt = 1'b0;
        busy_nxt     = 1'b0;
      end else if (emerge) begin
        out_vld_nxt = 1'b1;
        out_nxt     = res;
        busy_nxt    = 1'b0;
      end else begin
        out_vld_nxt = 1'b0;
      end
    end else if (emerge) begin
      // receiver stalled: park the result until the output register drains
      pend_vld_nxt = 1'b1;
      pend_nxt     = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      biu_r      <= bfa_pkg::BLOCKS_IN_USE_RST;
      busy_r     <= 1'b0;
      out_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        biu_r <= cfg_wdata;
      end
      busy_r     <= busy_nxt;
      out_vld_r  <= out_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
    req_r  <= req_nxt;
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

@@ rtl/bfa_checker.sv @@
// ----------------------------------------------------------------------------
// bfa_checker: port-level checks of the best-fit block allocator
// Watches the top level's channels and flags ordering and payload slips.
// ----------------------------------------------------------------------------
module bfa_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input bfa_pkg::bfa_in_t          in_data,
  input logic                      out_valid,
  input logic                      out_stall,
  input bfa_pkg::bfa_out_t         out_data,
  input logic                      cfg_we,
  input logic [bfa_pkg::CFG_W-1:0] cfg_wdata
);

  // a stalled result transaction stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // reset empties the result path
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // a no-fit result carries zero index and size
  a_nofit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.allocated |->
      (out_data.chosen_block == 4'd0) && (out_data.remaining_after == 16'd0))
    else $error("no-fit result with nonzero payload");

  // an accepted allocate holds off the next transaction while it searches
  a_alloc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.operation == bfa_pkg::OP_ALLOC) |=> in_stall)
    else $error("input taken during a search");

  // blocks_in_use must only change while no search is running (the block does not enforce it)
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |-> !in_stall && !$isunknown(cfg_wdata))
    else $error("blocks_in_use written during a search");

endmodule

bind best_fit_block_allocator bfa_checker u_bfa_checker (.*);
